// ===== hw/rtl/positional_insert_delete_list_defines.svh =====
// ----------------------------------------------------------------------------
// positional insert/delete list assertion macros
// shared property forms for the list's clocked checks
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_LIST_DEFINES_SVH

// condition that must hold at every clock edge outside reset
`define PIDL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

// consequence that must hold in the same cycle as the antecedent
`define PIDL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg
// shared widths, request codes and cell control type of the list
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned POS_W         = 5;
    localparam int unsigned REQ_W         = 2;
    localparam int unsigned COUNT_W       = 5;

    // request codes, code 3 is unused and always rejected
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_op;

endpackage

`default_nettype wire

// ===== hw/rtl/pidl_if.sv =====
// ----------------------------------------------------------------------------
// pidl request and response interfaces
// valid/ready channels carrying list requests and their results
// ----------------------------------------------------------------------------
`default_nettype none

interface pidl_req_if;
    import pidl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;

    modport source (output valid, output req_type, output position, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input new_value,
                    output ready);
endinterface

interface pidl_rsp_if;
    import pidl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] value;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, output ok, output value, output count, input ready);
    modport sink   (input valid, input ok, input value, input count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell
// one list slot: holds, loads, or takes its left or right neighbor's entry
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                          i_clk,
    input  pidl_pkg::t_cell_op            i_op,
    input  logic [pidl_pkg::DATA_W-1:0]   i_left,
    input  logic [pidl_pkg::DATA_W-1:0]   i_right,
    output logic [pidl_pkg::DATA_W-1:0]   o_value,
    output logic [pidl_pkg::DATA_W-1:0]   o_tap
);
    import pidl_pkg::*;

    // 1-based list position of this slot
    localparam int unsigned SLOT = INDEX + 1;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic              w_hit;
    logic              w_after;

    assign w_hit   = (32'(i_op.pos) == SLOT);
    assign w_after = (32'(i_op.pos) < SLOT);

    always_comb begin
        n_entry = r_entry;
        if (i_op.ins) begin
            if (w_hit) begin
                n_entry = i_op.value;
            end else if (w_after) begin
                n_entry = i_left;
            end
        end else if (i_op.del) begin
            if (w_hit || w_after) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_value = r_entry;
    // only the addressed slot drives the read bus
    assign o_tap   = w_hit ? r_entry : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_insert_delete_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// fixed-capacity ordered list addressed by 1-based position
// ----------------------------------------------------------------------------
// usage:
//   i_req carries one request per transaction: req_type (insert, delete,
//   read), a 1-based position and the value to insert. o_rsp returns one
//   result per request: ok, the removed or read value, and the entry count
//   after the request.
//   the result of an accepted request is registered and is valid from the
//   cycle after its acceptance on. throughput is one request per cycle
//   while o_rsp is not stalled; every slot of the cell chain shifts in the
//   same cycle, so no request waits on another. the output register frees
//   i_req.ready as soon as its result is taken, in the same cycle.
//   while o_rsp is stalled the held result stays put and i_req.ready is low.
//   reset empties the list (count zero) and drops any pending result; slot
//   contents are not cleared since positions beyond the count are never read.
//   rejected requests (bad position, full list, unused code) give ok low,
//   value zero and leave the list untouched.
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_insert_delete_list_defines.svh"

module positional_insert_delete_list #(
    parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pidl_req_if.sink     i_req,
    pidl_rsp_if.source   o_rsp
);
    import pidl_pkg::*;

    // count must hold DEPTH itself
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    // compare width wide enough for count + 1 and the position
    localparam int unsigned CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

    // list fill level
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // output register
    logic              r_out_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_value;

    logic              w_accept;
    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_cnt;
    logic              w_in_list;
    logic              w_ins_ok;
    logic              w_del_ok;
    logic              w_rd_ok;
    t_cell_op          w_op;

    // cell chain wiring
    logic [DATA_W-1:0] w_val [DEPTH];
    logic [DATA_W-1:0] w_tap [DEPTH];
    logic [DATA_W-1:0] w_rd;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // request checks against the current fill level
    assign w_pos     = CMP_W'(i_req.position);
    assign w_cnt     = CMP_W'(r_count);
    assign w_in_list = (i_req.position != '0) && (w_pos <= w_cnt);
    assign w_ins_ok  = (i_req.req_type == REQ_INSERT) && (w_cnt < CMP_W'(DEPTH))
                       && (i_req.position != '0) && (w_pos <= w_cnt + 1'b1);
    assign w_del_ok  = (i_req.req_type == REQ_DELETE) && w_in_list;
    assign w_rd_ok   = (i_req.req_type == REQ_READ) && w_in_list;

    // broadcast to all cells, shifts only for accepted valid requests
    always_comb begin
        w_op.ins   = w_accept && w_ins_ok;
        w_op.del   = w_accept && w_del_ok;
        w_op.pos   = i_req.position;
        w_op.value = i_req.new_value;
    end

    // the chain: slot k takes slot k-1 on insert, slot k+1 on delete
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (k == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body_l
            assign w_left = w_val[k-1];
        end

        // vacated tail slot fills with zero
        if (k == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body_r
            assign w_right = w_val[k+1];
        end

        pidl_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[k]),
            .o_tap   (w_tap[k])
        );
    end

    // at most one tap is nonzero, so an or-merge selects the addressed slot
    always_comb begin
        w_rd = '0;
        for (int unsigned k = 0; k < DEPTH; k++) begin
            w_rd = w_rd | w_tap[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_op.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_op.del) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_req.ready) begin
                r_out_valid <= i_req.valid;
            end
        end
    end

    // result payload, captured with the transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok    <= w_ins_ok || w_del_ok || w_rd_ok;
            r_value <= (w_del_ok || w_rd_ok) ? w_rd : '0;
        end
    end

    // count register already reflects the request held in the output stage
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.ok    = r_ok;
    assign o_rsp.value = r_value;
    assign o_rsp.count = COUNT_W'(r_count);

    `PIDL_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "list count exceeds capacity")
    `PIDL_ASSERT_NEXT(a_ins_count, w_op.ins, r_count == CW'($past(r_count) + 1'b1), "insert did not grow the list")
    `PIDL_ASSERT_NEXT(a_del_count, w_op.del, r_count == CW'($past(r_count) - 1'b1), "delete did not shrink the list")
    `PIDL_ASSERT_SAME(a_stall_block, r_out_valid && !o_rsp.ready, !i_req.ready, "request taken while result stalled")
    `PIDL_ASSERT_SAME(a_reject_zero, r_out_valid && !r_ok, r_value == '0, "rejected result carries a value")

endmodule

`default_nettype wire
